>>> rtl/core/gcc_pkg.sv
package gcc_pkg;

    localparam int EDGE_BITS = 28;
    localparam int COUNT_BITS = 28;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 28'h0FFF_FFFF;

    // excluded node codes are 3 bits wide, so they span this many nodes
    localparam int NODE_CODES = 8;
    localparam int NODE_CODE_BITS = 3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXCLUSION_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXCLUDED_NODE_A = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXCLUDED_NODE_B = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED     = 2'd0,
        VERDICT_EMPTY        = 2'd1,
        VERDICT_EXCLUDED     = 2'd2,
        VERDICT_DISCONNECTED = 2'd3
    } verdict_t;

    // traverse set: graph goes through reachability, else early holds the verdict
    typedef struct packed {
        logic     traverse;
        verdict_t early;
    } class_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_FINISH
    } back_state_t;

endpackage

>>> rtl/core/graph_connectivity_check.sv
// Connectivity check of one undirected graph per request, NODES nodes, edges given as the
// 28 upper-triangle bits of the adjacency matrix (bit 0 is edge (0,1), row-major). The front
// end builds the adjacency rows, finds participants and the excluded-pair hit in the cycle a
// request is taken, and queues up to two classified graphs. The back end grows reachability
// one frontier expansion per cycle and stops as soon as the set stops growing; empty and
// excluded graphs skip the expansion. Sustained rate is set by that expansion loop.
// accepted_total is the saturating count of accepted graphs including the result it comes
// with. Configuration: index 0 exclusion enable, 1 excluded node a, 2 excluded node b, to
// be written by the user only while the block is idle; the block does not enforce this.
module graph_connectivity_check #(
    parameter int NODES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gcc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gcc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gcc_pkg::EDGE_BITS-1:0]       edge_mask,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_connected,
    output logic [1:0]                          verdict,
    output logic [gcc_pkg::COUNT_BITS-1:0]      accepted_total
);

    localparam int ADJ_W = NODES * NODES;
    localparam int CLS_W = $bits(gcc_pkg::class_t);
    localparam int QW    = ADJ_W + 2 * NODES + CLS_W;

    logic                   push, pop, q_full, q_empty;
    logic [ADJ_W-1:0]       f_adj;
    logic [NODES-1:0]       f_part, f_start;
    gcc_pkg::class_t        f_cls, q_cls;
    logic [QW-1:0]          q_din, q_dout;

    gcc_front #(.NODES(NODES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .edge_mask (edge_mask),
        .q_full    (q_full),
        .push      (push),
        .adj_flat  (f_adj),
        .part      (f_part),
        .start     (f_start),
        .cls       (f_cls)
    );

    assign q_din = {f_adj, f_part, f_start, f_cls};

    gcc_queue #(.WIDTH(QW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .pop   (pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_cls = gcc_pkg::class_t'(q_dout[CLS_W-1:0]);

    gcc_back #(.NODES(NODES)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .pop            (pop),
        .q_adj          (q_dout[QW-1 -: ADJ_W]),
        .q_part         (q_dout[CLS_W+2*NODES-1 -: NODES]),
        .q_start        (q_dout[CLS_W+NODES-1 -: NODES]),
        .q_cls          (q_cls),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_connected   (is_connected),
        .verdict        (verdict),
        .accepted_total (accepted_total)
    );

endmodule

>>> rtl/core/gcc_front.sv
module gcc_front #(
    parameter int NODES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gcc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gcc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gcc_pkg::EDGE_BITS-1:0]       edge_mask,
    input  logic                                q_full,
    output logic                                push,
    output logic [NODES*NODES-1:0]              adj_flat,
    output logic [NODES-1:0]                    part,
    output logic [NODES-1:0]                    start,
    output gcc_pkg::class_t                     cls
);

    logic                                  exclusion_enable_reg;
    logic [gcc_pkg::NODE_CODE_BITS-1:0]    excluded_node_a_reg;
    logic [gcc_pkg::NODE_CODE_BITS-1:0]    excluded_node_b_reg;
    logic [gcc_pkg::NODE_CODES-1:0]        part8;
    logic                                  pair_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exclusion_enable_reg <= 1'b1;
            excluded_node_a_reg  <= 3'd0;
            excluded_node_b_reg  <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gcc_pkg::CFG_EXCLUSION_ENABLE: exclusion_enable_reg <= cfg_data[0];
                gcc_pkg::CFG_EXCLUDED_NODE_A:  excluded_node_a_reg  <= cfg_data;
                gcc_pkg::CFG_EXCLUDED_NODE_B:  excluded_node_b_reg  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // row-major upper triangle: pair (r,c), r<c, sits at r*(2N-r-1)/2 + c-r-1
    for (genvar r = 0; r < NODES; r++)
    begin : g_row
        for (genvar c = 0; c < NODES; c++)
        begin : g_col
            localparam int LO = (r < c) ? r : c;
            localparam int HI = (r < c) ? c : r;
            localparam int BIT = LO * (2 * NODES - LO - 1) / 2 + HI - LO - 1;
            if (r != c && BIT < gcc_pkg::EDGE_BITS)
            begin : g_edge
                assign adj_flat[r*NODES+c] = edge_mask[BIT];
            end
            else
            begin : g_none
                assign adj_flat[r*NODES+c] = 1'b0;
            end
        end
        assign part[r] = |adj_flat[r*NODES +: NODES];
    end

    // node codes at or above NODES never take part
    for (genvar k = 0; k < gcc_pkg::NODE_CODES; k++)
    begin : g_code
        if (k < NODES)
        begin : g_in
            assign part8[k] = part[k];
        end
        else
        begin : g_out
            assign part8[k] = 1'b0;
        end
    end

    assign pair_hit = exclusion_enable_reg && part8[excluded_node_a_reg]
                      && part8[excluded_node_b_reg];

    // lowest participant as a one-hot seed
    assign start = part & (~part + {{(NODES-1){1'b0}}, 1'b1});

    always_comb
    begin
        cls.traverse = (part != '0) && !pair_hit;
        if (part == '0)
            cls.early = gcc_pkg::VERDICT_EMPTY;
        else if (pair_hit)
            cls.early = gcc_pkg::VERDICT_EXCLUDED;
        else
            cls.early = gcc_pkg::VERDICT_ACCEPTED;
    end

endmodule

>>> rtl/core/gcc_queue.sv
module gcc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entries_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

>>> rtl/core/gcc_back.sv
module gcc_back #(
    parameter int NODES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              pop,
    input  logic [NODES*NODES-1:0]            q_adj,
    input  logic [NODES-1:0]                  q_part,
    input  logic [NODES-1:0]                  q_start,
    input  gcc_pkg::class_t                   q_cls,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              is_connected,
    output logic [1:0]                        verdict,
    output logic [gcc_pkg::COUNT_BITS-1:0]    accepted_total
);

    gcc_pkg::back_state_t              state_reg, state_next;
    logic [NODES*NODES-1:0]            adj_reg;
    logic [NODES-1:0]                  part_reg;
    logic [NODES-1:0]                  reach_reg;
    gcc_pkg::class_t                   cls_reg;
    logic                              out_valid_reg;
    logic                              is_connected_reg;
    gcc_pkg::verdict_t                 verdict_reg;
    logic [gcc_pkg::COUNT_BITS-1:0]    count_reg, count_next;
    logic [NODES-1:0]                  grown;
    logic                              load, advance, finish, slot_free;
    gcc_pkg::verdict_t                 final_verdict;

    // one frontier expansion
    always_comb
    begin
        grown = reach_reg;
        for (int i = 0; i < NODES; i++)
            if (reach_reg[i])
                grown = grown | adj_reg[i*NODES +: NODES];
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (!cls_reg.traverse)
            final_verdict = cls_reg.early;
        else if ((part_reg & ~reach_reg) == '0)
            final_verdict = gcc_pkg::VERDICT_ACCEPTED;
        else
            final_verdict = gcc_pkg::VERDICT_DISCONNECTED;
        if (final_verdict == gcc_pkg::VERDICT_ACCEPTED && count_reg != gcc_pkg::COUNT_MAX)
            count_next = count_reg + {{(gcc_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gcc_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load       = 1'b0;
        advance    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            gcc_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop  = 1'b1;
                    load = 1'b1;
                    state_next = q_cls.traverse ? gcc_pkg::B_RUN : gcc_pkg::B_FINISH;
                end
            end
            gcc_pkg::B_RUN:
            begin
                // stop once the reached set no longer grows
                if (grown == reach_reg)
                    state_next = gcc_pkg::B_FINISH;
                else
                    advance = 1'b1;
            end
            gcc_pkg::B_FINISH:
            begin
                if (slot_free)
                begin
                    finish     = 1'b1;
                    state_next = gcc_pkg::B_IDLE;
                end
            end
            default: state_next = gcc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= '0;
            cls_reg   <= '0;
        end
        else if (load)
        begin
            reach_reg <= q_cls.traverse ? q_start : '0;
            cls_reg   <= q_cls;
        end
        else if (advance)
            reach_reg <= grown;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            adj_reg  <= q_adj;
            part_reg <= q_part;
        end
        if (finish)
        begin
            verdict_reg      <= final_verdict;
            is_connected_reg <= (final_verdict == gcc_pkg::VERDICT_ACCEPTED);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
            count_reg     <= count_next;
        end
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign is_connected   = is_connected_reg;
    assign verdict        = verdict_reg;
    assign accepted_total = count_reg;

`ifndef ASSERT_OFF
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1 |=> count_reg >= $past(count_reg))
        else $error("accepted count went down");

    a_count_moves_with_accept: assert property (@(posedge clk) disable iff (!rst_n)
        1 |=> (count_reg == $past(count_reg))
              || (out_valid_reg && verdict_reg == gcc_pkg::VERDICT_ACCEPTED))
        else $error("accepted count changed without an accepted result");

    a_flag_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> is_connected_reg == (verdict_reg == gcc_pkg::VERDICT_ACCEPTED))
        else $error("is_connected disagrees with verdict");

    a_run_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gcc_pkg::B_RUN |-> reach_reg != '0)
        else $error("traversal running with an empty reached set");
`endif

endmodule
